FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge while reset is low.
`define S256_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("s256 assertion failed");
// Checked on every clock edge, also during reset.
`define S256_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("s256 assertion failed");
`else
`define S256_ASSERT(lbl, clk, rst, prop)
`define S256_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockWords = 16;
   localparam logic [7:0]  PadByte    = 8'h80;
   localparam logic [63:0] BitCountMax = 64'hFFFF_FFFF_FFFF_FFF8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
      logic        too_long;
   } rsp_type;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_FIN   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // Control from the sequencer to the round datapath.
   typedef struct packed {
      logic       load;
      logic       step;
      logic [5:0] rnd;
   } core_ctrl_type;

   typedef logic [31:0] word_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type ror32(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type big_sig0(input word_type x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

endpackage

FILE: sv/s256_ram.sv
// ----------------------------------------------------------------------------
// s256_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module s256_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/s256_core.sv
// ----------------------------------------------------------------------------
// s256_core
// SHA-256 round datapath: working variables and message schedule window.
// ----------------------------------------------------------------------------
module s256_core (
   input  logic                    clock,
   input  s256_pkg::core_ctrl_type ctrl,
   input  s256_pkg::word_type      hash_in [8],
   input  s256_pkg::word_type      mem_word,
   output s256_pkg::word_type      work_out [8]
);

   s256_pkg::word_type v_ff [8];
   s256_pkg::word_type v_in [8];
   s256_pkg::word_type win_ff [16];
   s256_pkg::word_type w_next;
   s256_pkg::word_type w_cur;
   s256_pkg::word_type t1;
   s256_pkg::word_type t2;

   // The first sixteen schedule words come from the block buffer, the rest
   // from the sliding window of the last sixteen.
   always_comb begin
      w_next = win_ff[0] + s256_pkg::small_sig0(win_ff[1]) + win_ff[9]
             + s256_pkg::small_sig1(win_ff[14]);
      w_cur  = (ctrl.rnd < 6'd16) ? mem_word : w_next;
   end

   // One compression round.
   always_comb begin
      t1 = v_ff[7] + s256_pkg::big_sig1(v_ff[4])
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + s256_pkg::RoundK[ctrl.rnd] + w_cur;
      t2 = s256_pkg::big_sig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in[7] = v_ff[6];
      v_in[6] = v_ff[5];
      v_in[5] = v_ff[4];
      v_in[4] = v_ff[3] + t1;
      v_in[3] = v_ff[2];
      v_in[2] = v_ff[1];
      v_in[1] = v_ff[0];
      v_in[0] = t1 + t2;
   end

   // Working registers load from the hash, then advance once per round.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         v_ff <= hash_in;
      end else if (ctrl.step) begin
         v_ff <= v_in;
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[15] <= w_cur;
      end
   end

   assign work_out = v_ff;

endmodule

FILE: sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256 with padding and a digest of eight words per message.
// ----------------------------------------------------------------------------
//  channel | direction | payload       | handshake
//  req_    | in        | req_type      | req_valid / req_stall
//  rsp_    | out       | rsp_type      | rsp_valid / rsp_stall
//
//  A plain byte is absorbed as it is taken; a byte that fills the block adds
//  a buffer read setup, 64 rounds on the shared round unit and a hash update.
//  The end item pads one byte per cycle into the buffer RAM, compressing one
//  or two more blocks, then presents eight digest words, one per transfer.
//  Reset is synchronous; it restores the initial hash and an empty block.
//  req_stall is high whenever the sequencer is not idle; a stalled digest
//  word holds.
`include "assert_macros.svh"

module sha256_stream_hasher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  s256_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output s256_pkg::rsp_type rsp_data
);

   s256_pkg::state_type     state_ff, state_in;
   s256_pkg::word_type      hash_ff [8];
   s256_pkg::word_type      work [8];
   s256_pkg::word_type      mem_word;
   s256_pkg::core_ctrl_type ctrl;
   logic [63:0] bits_ff, bits_in;
   logic        ovf_ff, ovf_in;
   logic [6:0]  pos_ff, pos_in;
   logic [23:0] wacc_ff;
   logic [5:0]  rnd_ff, rnd_in;
   logic [3:0]  len_ff, len_in;
   logic        sent_ff, sent_in;
   logic        endp_ff, endp_in;
   logic [2:0]  idx_ff, idx_in;
   logic        req_xfer, rsp_xfer;
   logic        absorb_en, block_full, finish;
   logic [7:0]  absorb_byte, pad_byte;
   logic [3:0]  rd_addr;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != s256_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == s256_pkg::ST_OUT);
   assign finish    = rsp_xfer && (idx_ff == 3'd7);

   // Padding byte: the marker, zeros up to the length field, then the length.
   always_comb begin
      if (!sent_ff) begin
         pad_byte = s256_pkg::PadByte;
      end else if (len_ff == 4'd0 && pos_ff != 7'd56) begin
         pad_byte = 8'h00;
      end else begin
         pad_byte = bits_ff[8 * (7 - len_ff[2:0]) +: 8];
      end
   end

   // Byte path into the block buffer, one byte per cycle while idle or padding.
   assign absorb_en = (state_ff == s256_pkg::ST_PAD)
                   || (req_xfer && req_data.has_byte);
   assign absorb_byte = (state_ff == s256_pkg::ST_PAD) ? pad_byte : req_data.data_byte;
   assign block_full  = absorb_en && (pos_ff == 7'd63);
   assign rd_addr     = (state_ff == s256_pkg::ST_LOAD) ? 4'd0 : (rnd_ff[3:0] + 4'd1);

   s256_ram #(
      .Width (s256_pkg::WordWidth),
      .Depth (s256_pkg::BlockWords)
   ) u_buf (
      .clock   (clock),
      .wr_en   (absorb_en && (pos_ff[1:0] == 2'b11)),
      .wr_addr (pos_ff[5:2]),
      .wr_data ({wacc_ff, absorb_byte}),
      .rd_addr (rd_addr),
      .rd_data (mem_word)
   );

   assign ctrl.load = (state_ff == s256_pkg::ST_LOAD);
   assign ctrl.step = (state_ff == s256_pkg::ST_ROUND);
   assign ctrl.rnd  = rnd_ff;

   s256_core u_core (
      .clock    (clock),
      .ctrl     (ctrl),
      .hash_in  (hash_ff),
      .mem_word (mem_word),
      .work_out (work)
   );

   // Sequencer and counters.
   always_comb begin
      state_in = state_ff;
      bits_in  = bits_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      len_in   = len_ff;
      sent_in  = sent_ff;
      endp_in  = endp_ff;
      idx_in   = idx_ff;
      if (absorb_en) begin
         pos_in = block_full ? 7'd0 : (pos_ff + 7'd1);
      end
      case (state_ff)
         s256_pkg::ST_IDLE: begin
            if (req_xfer) begin
               endp_in = req_data.message_end;
               if (req_data.has_byte) begin
                  if (bits_ff >= s256_pkg::BitCountMax) begin
                     ovf_in = 1'b1;
                  end else begin
                     bits_in = bits_ff + 64'd8;
                  end
               end
               if (block_full) begin
                  state_in = s256_pkg::ST_LOAD;
               end else if (req_data.message_end) begin
                  state_in = s256_pkg::ST_PAD;
               end
            end
         end
         s256_pkg::ST_PAD: begin
            if (!sent_ff) begin
               sent_in = 1'b1;
            end else if (len_ff != 4'd0 || pos_ff == 7'd56) begin
               len_in = len_ff + 4'd1;
            end
            if (block_full) begin
               state_in = s256_pkg::ST_LOAD;
            end
         end
         s256_pkg::ST_LOAD: begin
            rnd_in   = 6'd0;
            state_in = s256_pkg::ST_ROUND;
         end
         s256_pkg::ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = s256_pkg::ST_FIN;
            end
         end
         s256_pkg::ST_FIN: begin
            if (!endp_ff) begin
               state_in = s256_pkg::ST_IDLE;
            end else if (len_ff == 4'd8) begin
               state_in = s256_pkg::ST_OUT;
            end else begin
               state_in = s256_pkg::ST_PAD;
            end
         end
         s256_pkg::ST_OUT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
            end
            if (finish) begin
               state_in = s256_pkg::ST_IDLE;
               bits_in  = '0;
               ovf_in   = 1'b0;
               pos_in   = '0;
               len_in   = '0;
               sent_in  = 1'b0;
               endp_in  = 1'b0;
            end
         end
         default: begin
            state_in = s256_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s256_pkg::ST_IDLE;
         bits_ff  <= '0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
         rnd_ff   <= '0;
         len_ff   <= '0;
         sent_ff  <= 1'b0;
         endp_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bits_ff  <= bits_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
         len_ff   <= len_in;
         sent_ff  <= sent_in;
         endp_ff  <= endp_in;
         idx_ff   <= idx_in;
      end
   end

   // Byte assembly into big-endian buffer words.
   always_ff @(posedge clock) begin
      if (absorb_en) begin
         wacc_ff <= {wacc_ff[15:0], absorb_byte};
      end
   end

   // Chaining hash: initial values after reset or a delivered digest.
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         hash_ff <= s256_pkg::InitHash;
      end else if (state_ff == s256_pkg::ST_FIN) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + work[i];
         end
      end
   end

   // Digest word under transfer.
   always_comb begin
      rsp_data.digest_word = hash_ff[idx_ff];
      rsp_data.word_index  = idx_ff;
      rsp_data.last_word   = (idx_ff == 3'd7);
      rsp_data.too_long    = ovf_ff;
   end

   `S256_ASSERT(a_idle_no_rsp, clock, reset, !req_stall |-> !rsp_valid)
   `S256_ASSERT(a_last_ends, clock, reset, finish |=> !rsp_valid && !req_stall)
   `S256_ASSERT(a_pos_range, clock, reset, pos_ff < 7'd64)
   `S256_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule
